// ===== rtl/core/scu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scu_pkg: shared types and constants for symmetrical components unbalance
// Word formats, fixed-point widths, sine coefficients and phase/set maps.
// ---------------------------------------------------------------------------
package scu_pkg;

  localparam int MAG_BITS   = 16;
  localparam int ANGLE_BITS = 16;
  localparam int RATIO_BITS = 16;

  localparam int PHASES   = 3;
  localparam int COMPS    = 3;
  localparam int NUM_SETS = 7;
  localparam int LANES    = 2 * NUM_SETS;

  // component order
  localparam int COMP_POS  = 0;
  localparam int COMP_NEG  = 1;
  localparam int COMP_ZERO = 2;

  // angle sets: A, B, B+120, B-120, C, C+120, C-120
  localparam int SET_A  = 0;
  localparam int SET_B0 = 1;
  localparam int SET_BP = 2;
  localparam int SET_BM = 3;
  localparam int SET_C0 = 4;
  localparam int SET_CP = 5;
  localparam int SET_CM = 6;

  localparam int SET_PHASE [NUM_SETS] = '{0, 1, 1, 1, 2, 2, 2};
  localparam int COMP_SETS [COMPS][PHASES] = '{
    '{SET_A, SET_BP, SET_CM},
    '{SET_A, SET_BM, SET_CP},
    '{SET_A, SET_B0, SET_C0}
  };

  // sine polynomial, Q30
  localparam int Q_FRAC    = 30;
  localparam int TRIG_BITS = Q_FRAC + 1;
  localparam int SIN_BITS  = Q_FRAC + 1;
  localparam logic [TRIG_BITS-1:0] Q30_ONE = {1'b1, {Q_FRAC{1'b0}}};
  localparam logic [TRIG_BITS-1:0] SINE_COEF [5] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272
  };

  localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] ANG_THIRD =
    ANGLE_BITS'(((longint'(1) << ANGLE_BITS) + 1) / 3);

  // phasor sums and modulus
  localparam int PROD_BITS = MAG_BITS + SIN_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int ABS_BITS  = SUM_BITS - 1;
  localparam int LO_BITS   = ABS_BITS / 2;
  localparam int HI_BITS   = ABS_BITS - LO_BITS;
  localparam int SQ_BITS   = 2 * ABS_BITS;
  localparam int NSUM_BITS = SQ_BITS + 1;
  localparam int NH_SHIFT  = 2 * (Q_FRAC - 2);
  localparam int NH_BITS   = NSUM_BITS - NH_SHIFT;

  // rounded magnitude search
  localparam int M_BITS    = MAG_BITS + 1;
  localparam int V_BITS    = M_BITS + 1;
  localparam int VSQ_BITS  = 2 * V_BITS;
  localparam int VSQ9_BITS = VSQ_BITS + 4;
  localparam logic [M_BITS-1:0] MAG_MAX = {1'b0, {MAG_BITS{1'b1}}};

  // ratio
  localparam int SCALE_BITS = 14;
  localparam logic [SCALE_BITS-1:0] RATIO_SCALE = 14'd10000;
  localparam int NUM_BITS = MAG_BITS + SCALE_BITS;
  localparam int DIV_BITS = MAG_BITS + RATIO_BITS;
  localparam int RAT_NEG  = 0;
  localparam int RAT_ZERO = 1;

  // pipeline depth
  localparam int TRIG_STAGES   = 7;
  localparam int PHASOR_STAGES = 5;
  localparam int MAG_STEPS     = M_BITS;
  localparam int RATIO_STAGES  = RATIO_BITS + 3;
  localparam int LATENCY = TRIG_STAGES + PHASOR_STAGES + MAG_STEPS + RATIO_STAGES;

  typedef logic [MAG_BITS-1:0] mag_t;
  typedef logic signed [SIN_BITS-1:0] sine_t;
  typedef logic [NH_BITS-1:0] nh_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]   phase_a_magnitude;
    logic [ANGLE_BITS-1:0] phase_a_angle;
    logic [MAG_BITS-1:0]   phase_b_magnitude;
    logic [ANGLE_BITS-1:0] phase_b_angle;
    logic [MAG_BITS-1:0]   phase_c_magnitude;
    logic [ANGLE_BITS-1:0] phase_c_angle;
  } scu_in_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]   positive_magnitude;
    logic [MAG_BITS-1:0]   negative_magnitude;
    logic [MAG_BITS-1:0]   zero_magnitude;
    logic [RATIO_BITS-1:0] negative_unbalance;
    logic [RATIO_BITS-1:0] zero_unbalance;
    logic                  no_positive;
  } scu_out_t;

endpackage

// ===== rtl/core/symmetrical_components_unbalance_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// symmetrical_components_unbalance_top: three-phase sequence components
// One phasor set per cycle in, one result word per set out.
// ---------------------------------------------------------------------------
// A word is taken at every clock with start high and busy low; busy is high
// only while reset is applied. Each accepted word yields exactly one result
// word on out_data, flagged by out_valid for one cycle, in order of acceptance.
// The result side has no back-pressure: the receiver must take every word as
// it appears. Depth is set by the sine polynomial (7 stages), the phasor
// product/square stages (5), the 17-step magnitude search and the 16-step
// ratio divider plus its input and output registers.
module symmetrical_components_unbalance_top
  import scu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  scu_in_t  in_data,
  output logic     out_valid,
  output scu_out_t out_data
);

  logic  accept;
  logic  trig_valid;
  sine_t trig_sine [LANES];
  mag_t  trig_mag [PHASES];
  logic  ph_valid;
  nh_t   ph_nh [COMPS];
  logic  mag_valid;
  mag_t  comp_mag [COMPS];

  assign busy   = !rst_n;
  assign accept = start && !busy;

  scu_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_word   (in_data),
    .out_valid (trig_valid),
    .sine      (trig_sine),
    .mag       (trig_mag)
  );

  scu_phasor u_phasor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .sine      (trig_sine),
    .mag       (trig_mag),
    .out_valid (ph_valid),
    .nh        (ph_nh)
  );

  scu_mag u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_valid),
    .nh        (ph_nh),
    .out_valid (mag_valid),
    .mag       (comp_mag)
  );

  scu_ratio u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mag_valid),
    .mag       (comp_mag),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

endmodule

// ===== rtl/core/scu_trig.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scu_trig: pipelined sine/cosine of the seven rotated phase angles
// Quarter-wave odd polynomial, at most one multiply per stage, Q29 signed result.
// ---------------------------------------------------------------------------
module scu_trig
  import scu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  scu_in_t in_word,
  output logic    out_valid,
  output sine_t   sine [LANES],
  output mag_t    mag [PHASES]
);

  logic [ANGLE_BITS-1:0] ang_set [NUM_SETS];
  logic [ANGLE_BITS-1:0] lane_ang [LANES];
  logic [TRIG_BITS-1:0]  x_nxt [LANES];
  logic [TRIG_BITS-1:0]  t_nxt [LANES];
  logic [TRIG_BITS-1:0]  p_nxt [4][LANES];
  logic [2*TRIG_BITS-1:0] sq_c [LANES];
  logic [2*TRIG_BITS-1:0] hp_c [4][LANES];
  logic [2*TRIG_BITS-1:0] fp_c [LANES];
  logic [TRIG_BITS-1:0]  fq_c [LANES];
  logic [SIN_BITS-1:0]   s_c [LANES];
  sine_t                 sine_nxt [LANES];

  logic [TRIG_BITS-1:0] x_r [6][LANES];
  logic                 neg_r [6][LANES];
  logic [TRIG_BITS-1:0] t_r [4][LANES];
  logic [TRIG_BITS-1:0] p_r [4][LANES];
  sine_t                sine_r [LANES];
  mag_t                 mag_r [TRIG_STAGES][PHASES];
  logic [TRIG_STAGES-1:0] valid_r;

  always_comb begin
    ang_set[SET_A]  = in_word.phase_a_angle;
    ang_set[SET_B0] = in_word.phase_b_angle;
    ang_set[SET_BP] = in_word.phase_b_angle + ANG_THIRD;
    ang_set[SET_BM] = in_word.phase_b_angle - ANG_THIRD;
    ang_set[SET_C0] = in_word.phase_c_angle;
    ang_set[SET_CP] = in_word.phase_c_angle + ANG_THIRD;
    ang_set[SET_CM] = in_word.phase_c_angle - ANG_THIRD;
    for (int l = 0; l < LANES; l++) begin
      lane_ang[l] = ang_set[l / 2] + (((l % 2) == 1) ? ANG_QUARTER : '0);
      x_nxt[l] = TRIG_BITS'(lane_ang[l][ANGLE_BITS-3:0]) << (Q_FRAC - (ANGLE_BITS - 2));
      if (lane_ang[l][ANGLE_BITS-2]) begin
        x_nxt[l] = Q30_ONE - x_nxt[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq_c[l]  = x_r[0][l] * x_r[0][l];
      t_nxt[l] = TRIG_BITS'(sq_c[l] >> Q_FRAC);
      for (int i = 0; i < 4; i++) begin
        if (i == 0) begin
          hp_c[i][l] = SINE_COEF[4] * t_r[i][l];
        end else begin
          hp_c[i][l] = p_r[i-1][l] * t_r[i][l];
        end
        p_nxt[i][l] = SINE_COEF[3-i] - TRIG_BITS'(hp_c[i][l] >> Q_FRAC);
      end
      fp_c[l] = p_r[3][l] * x_r[5][l];
      fq_c[l] = TRIG_BITS'(fp_c[l] >> Q_FRAC);
      if (fq_c[l] > Q30_ONE) begin
        fq_c[l] = Q30_ONE;
      end
      s_c[l] = SIN_BITS'(fq_c[l] >> 1);
      sine_nxt[l] = neg_r[5][l] ? -$signed(s_c[l]) : $signed(s_c[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      x_r[0][l]   <= x_nxt[l];
      neg_r[0][l] <= lane_ang[l][ANGLE_BITS-1];
      for (int s = 1; s < 6; s++) begin
        x_r[s][l]   <= x_r[s-1][l];
        neg_r[s][l] <= neg_r[s-1][l];
      end
      t_r[0][l] <= t_nxt[l];
      for (int i = 1; i < 4; i++) begin
        t_r[i][l] <= t_r[i-1][l];
      end
      for (int i = 0; i < 4; i++) begin
        p_r[i][l] <= p_nxt[i][l];
      end
      sine_r[l] <= sine_nxt[l];
    end
    mag_r[0][0] <= in_word.phase_a_magnitude;
    mag_r[0][1] <= in_word.phase_b_magnitude;
    mag_r[0][2] <= in_word.phase_c_magnitude;
    for (int s = 1; s < TRIG_STAGES; s++) begin
      mag_r[s] <= mag_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[TRIG_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = valid_r[TRIG_STAGES-1];
  assign sine      = sine_r;
  assign mag       = mag_r[TRIG_STAGES-1];

endmodule

// ===== rtl/core/scu_phasor.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scu_phasor: sequence phasor sums and squared modulus
// Products, sums, split squares; returns the squared modulus scaled down.
// ---------------------------------------------------------------------------
module scu_phasor
  import scu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  sine_t sine [LANES],
  input  mag_t  mag [PHASES],
  output logic  out_valid,
  output nh_t   nh [COMPS]
);

  logic signed [PROD_BITS-1:0] prod_r [LANES];
  logic signed [SUM_BITS-1:0]  re_c [COMPS];
  logic signed [SUM_BITS-1:0]  im_c [COMPS];
  logic [ABS_BITS-1:0]         are_r [COMPS];
  logic [ABS_BITS-1:0]         aim_r [COMPS];
  logic [2*HI_BITS-1:0]        hh_re_r [COMPS];
  logic [HI_BITS+LO_BITS-1:0]  hl_re_r [COMPS];
  logic [2*LO_BITS-1:0]        ll_re_r [COMPS];
  logic [2*HI_BITS-1:0]        hh_im_r [COMPS];
  logic [HI_BITS+LO_BITS-1:0]  hl_im_r [COMPS];
  logic [2*LO_BITS-1:0]        ll_im_r [COMPS];
  logic [SQ_BITS-1:0]          sq_re_r [COMPS];
  logic [SQ_BITS-1:0]          sq_im_r [COMPS];
  logic [NSUM_BITS-1:0]        nsum_c [COMPS];
  nh_t                         nh_r [COMPS];
  logic [PHASOR_STAGES-1:0]    valid_r;

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      re_c[c] = prod_r[2*COMP_SETS[c][0]+1] + prod_r[2*COMP_SETS[c][1]+1]
              + prod_r[2*COMP_SETS[c][2]+1];
      im_c[c] = prod_r[2*COMP_SETS[c][0]] + prod_r[2*COMP_SETS[c][1]]
              + prod_r[2*COMP_SETS[c][2]];
      nsum_c[c] = NSUM_BITS'(sq_re_r[c]) + NSUM_BITS'(sq_im_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      prod_r[l] <= $signed({1'b0, mag[SET_PHASE[l/2]]}) * sine[l];
    end
    for (int c = 0; c < COMPS; c++) begin
      are_r[c] <= ABS_BITS'(re_c[c] < 0 ? -re_c[c] : re_c[c]);
      aim_r[c] <= ABS_BITS'(im_c[c] < 0 ? -im_c[c] : im_c[c]);
      hh_re_r[c] <= are_r[c][ABS_BITS-1:LO_BITS] * are_r[c][ABS_BITS-1:LO_BITS];
      hl_re_r[c] <= are_r[c][ABS_BITS-1:LO_BITS] * are_r[c][LO_BITS-1:0];
      ll_re_r[c] <= are_r[c][LO_BITS-1:0] * are_r[c][LO_BITS-1:0];
      hh_im_r[c] <= aim_r[c][ABS_BITS-1:LO_BITS] * aim_r[c][ABS_BITS-1:LO_BITS];
      hl_im_r[c] <= aim_r[c][ABS_BITS-1:LO_BITS] * aim_r[c][LO_BITS-1:0];
      ll_im_r[c] <= aim_r[c][LO_BITS-1:0] * aim_r[c][LO_BITS-1:0];
      sq_re_r[c] <= (SQ_BITS'(hh_re_r[c]) << (2*LO_BITS))
                  + (SQ_BITS'(hl_re_r[c]) << (LO_BITS+1)) + SQ_BITS'(ll_re_r[c]);
      sq_im_r[c] <= (SQ_BITS'(hh_im_r[c]) << (2*LO_BITS))
                  + (SQ_BITS'(hl_im_r[c]) << (LO_BITS+1)) + SQ_BITS'(ll_im_r[c]);
      nh_r[c] <= NH_BITS'(nsum_c[c] >> NH_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[PHASOR_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = valid_r[PHASOR_STAGES-1];
  assign nh        = nh_r;

endmodule

// ===== rtl/core/scu_mag.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scu_mag: rounded magnitude by bitwise search, one bit per stage
// Largest m with 9*(2m-1)^2 <= scaled squared modulus, clamped to range.
// ---------------------------------------------------------------------------
module scu_mag
  import scu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  nh_t  nh [COMPS],
  output logic out_valid,
  output mag_t mag [COMPS]
);

  logic [M_BITS-1:0]    m_src [MAG_STEPS][COMPS];
  nh_t                  nh_src [MAG_STEPS][COMPS];
  logic [M_BITS-1:0]    cand_c [MAG_STEPS][COMPS];
  logic [V_BITS-1:0]    v_c [MAG_STEPS][COMPS];
  logic [VSQ_BITS-1:0]  vsq_c [MAG_STEPS][COMPS];
  logic [VSQ9_BITS-1:0] vsq9_c [MAG_STEPS][COMPS];
  logic [M_BITS-1:0]    m_nxt [MAG_STEPS][COMPS];

  logic [M_BITS-1:0]    m_r [MAG_STEPS][COMPS];
  nh_t                  nh_r [MAG_STEPS-1][COMPS];
  logic [MAG_STEPS-1:0] valid_r;

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      m_src[0][c]  = '0;
      nh_src[0][c] = nh[c];
      for (int s = 1; s < MAG_STEPS; s++) begin
        m_src[s][c]  = m_r[s-1][c];
        nh_src[s][c] = nh_r[s-1][c];
      end
      for (int s = 0; s < MAG_STEPS; s++) begin
        cand_c[s][c] = m_src[s][c] | (M_BITS'(1) << (M_BITS - 1 - s));
        v_c[s][c]    = {cand_c[s][c], 1'b0} - V_BITS'(1);
        vsq_c[s][c]  = v_c[s][c] * v_c[s][c];
        vsq9_c[s][c] = (VSQ9_BITS'(vsq_c[s][c]) << 3) + VSQ9_BITS'(vsq_c[s][c]);
        m_nxt[s][c]  = (vsq9_c[s][c] <= nh_src[s][c]) ? cand_c[s][c] : m_src[s][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < COMPS; c++) begin
      for (int s = 0; s < MAG_STEPS; s++) begin
        m_r[s][c] <= m_nxt[s][c];
      end
      for (int s = 0; s < MAG_STEPS - 1; s++) begin
        nh_r[s][c] <= nh_src[s][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[MAG_STEPS-2:0], in_valid};
    end
  end

  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      mag[c] = (m_r[MAG_STEPS-1][c] > MAG_MAX) ? MAG_MAX[MAG_BITS-1:0]
                                               : m_r[MAG_STEPS-1][c][MAG_BITS-1:0];
    end
  end

  assign out_valid = valid_r[MAG_STEPS-1];

endmodule

// ===== rtl/core/scu_ratio.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scu_ratio: unbalance ratios by pipelined restoring division
// Rounded 10000*part/positive, saturated; output word register and strobe.
// ---------------------------------------------------------------------------
module scu_ratio
  import scu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  mag_t     mag [COMPS],
  output logic     out_valid,
  output scu_out_t out_word
);

  mag_t                  mag0_r [COMPS];
  logic [NUM_BITS-1:0]   n0_r [2];
  mag_t                  mag1_r [COMPS];
  logic [NUM_BITS-1:0]   n1_r [2];
  logic                  ovf1_r [2];

  logic [NUM_BITS-1:0]   rem_src [RATIO_BITS][2];
  logic [RATIO_BITS-1:0] q_src [RATIO_BITS][2];
  logic                  ovf_src [RATIO_BITS][2];
  mag_t                  mag_src [RATIO_BITS][COMPS];
  logic [DIV_BITS-1:0]   cmp_c [RATIO_BITS];
  logic [NUM_BITS-1:0]   rem_nxt [RATIO_BITS][2];
  logic [RATIO_BITS-1:0] q_nxt [RATIO_BITS][2];

  logic [NUM_BITS-1:0]   rem_r [RATIO_BITS-1][2];
  logic [RATIO_BITS-1:0] q_r [RATIO_BITS][2];
  logic                  ovf_r [RATIO_BITS][2];
  mag_t                  dmag_r [RATIO_BITS][COMPS];

  logic                  v0_r;
  logic                  v1_r;
  logic [RATIO_BITS-1:0] dv_r;
  logic                  out_valid_r;
  scu_out_t              out_word_r;
  scu_out_t              out_word_nxt;
  mag_t                  pos_f;

  always_comb begin
    for (int k = 0; k < COMPS; k++) begin
      mag_src[0][k] = mag1_r[k];
      for (int j = 1; j < RATIO_BITS; j++) begin
        mag_src[j][k] = dmag_r[j-1][k];
      end
    end
    for (int r = 0; r < 2; r++) begin
      rem_src[0][r] = n1_r[r];
      q_src[0][r]   = '0;
      ovf_src[0][r] = ovf1_r[r];
      for (int j = 1; j < RATIO_BITS; j++) begin
        rem_src[j][r] = rem_r[j-1][r];
        q_src[j][r]   = q_r[j-1][r];
        ovf_src[j][r] = ovf_r[j-1][r];
      end
    end
    for (int j = 0; j < RATIO_BITS; j++) begin
      cmp_c[j] = DIV_BITS'(mag_src[j][COMP_POS]) << (RATIO_BITS - 1 - j);
      for (int r = 0; r < 2; r++) begin
        if (DIV_BITS'(rem_src[j][r]) >= cmp_c[j]) begin
          rem_nxt[j][r] = rem_src[j][r] - NUM_BITS'(cmp_c[j]);
          q_nxt[j][r]   = q_src[j][r] | (RATIO_BITS'(1) << (RATIO_BITS - 1 - j));
        end else begin
          rem_nxt[j][r] = rem_src[j][r];
          q_nxt[j][r]   = q_src[j][r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mag0_r <= mag;
    n0_r[RAT_NEG]  <= NUM_BITS'(mag[COMP_NEG]) * NUM_BITS'(RATIO_SCALE)
                    + NUM_BITS'(mag[COMP_POS] >> 1);
    n0_r[RAT_ZERO] <= NUM_BITS'(mag[COMP_ZERO]) * NUM_BITS'(RATIO_SCALE)
                    + NUM_BITS'(mag[COMP_POS] >> 1);
    mag1_r <= mag0_r;
    for (int r = 0; r < 2; r++) begin
      n1_r[r]   <= n0_r[r];
      ovf1_r[r] <= DIV_BITS'(n0_r[r]) >= {mag0_r[COMP_POS], {RATIO_BITS{1'b0}}};
    end
    for (int j = 0; j < RATIO_BITS; j++) begin
      dmag_r[j] <= mag_src[j];
      for (int r = 0; r < 2; r++) begin
        q_r[j][r]   <= q_nxt[j][r];
        ovf_r[j][r] <= ovf_src[j][r];
      end
    end
    for (int j = 0; j < RATIO_BITS - 1; j++) begin
      for (int r = 0; r < 2; r++) begin
        rem_r[j][r] <= rem_nxt[j][r];
      end
    end
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    pos_f = dmag_r[RATIO_BITS-1][COMP_POS];
    out_word_nxt.positive_magnitude = pos_f;
    out_word_nxt.negative_magnitude = dmag_r[RATIO_BITS-1][COMP_NEG];
    out_word_nxt.zero_magnitude     = dmag_r[RATIO_BITS-1][COMP_ZERO];
    if (pos_f == '0) begin
      out_word_nxt.negative_unbalance = '0;
      out_word_nxt.zero_unbalance     = '0;
      out_word_nxt.no_positive        = 1'b1;
    end else begin
      out_word_nxt.negative_unbalance = ovf_r[RATIO_BITS-1][RAT_NEG] ? '1
                                      : q_r[RATIO_BITS-1][RAT_NEG];
      out_word_nxt.zero_unbalance     = ovf_r[RATIO_BITS-1][RAT_ZERO] ? '1
                                      : q_r[RATIO_BITS-1][RAT_ZERO];
      out_word_nxt.no_positive        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      dv_r        <= {dv_r[RATIO_BITS-2:0], v1_r};
      out_valid_r <= dv_r[RATIO_BITS-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/scu_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scu_checker: port-level checks for the unbalance block
// Fixed latency and consistency of the result word fields.
// ---------------------------------------------------------------------------
module scu_checker
  import scu_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input scu_out_t out_data
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result word without matching input word");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.no_positive == (out_data.positive_magnitude == '0)))
    else $error("no_positive flag mismatch");

  a_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_positive |->
      out_data.negative_unbalance == '0 && out_data.zero_unbalance == '0)
    else $error("ratios not cleared");

  a_unit_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.no_positive &&
      out_data.negative_magnitude == out_data.positive_magnitude |->
      out_data.negative_unbalance == RATIO_BITS'(RATIO_SCALE))
    else $error("equal components must give full scale ratio");

  a_null_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_magnitude == '0 |-> out_data.zero_unbalance == '0)
    else $error("zero component must give zero ratio");

endmodule

bind symmetrical_components_unbalance_top scu_checker u_scu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
